### src/sle_pkg.sv
package sle_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned OccW        = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_POP    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_POP    = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic     sample;
    cell_op_e op;
  } cell_ctrl_t;

endpackage

### src/sle_if.sv
interface sle_req_if;
  import sle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sle_rsp_if;
  import sle_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [ValueW-1:0] result_value;
  logic [OccW-1:0]          occupancy;

  modport source (output valid, output status, output result_value, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input result_value, input occupancy,
                  output ready);
endinterface

### src/sle_cell.sv
module sle_cell
  import sle_pkg::*;
#(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cell_ctrl_t               ctrl_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic signed [ValueW-1:0] cmp_value_i,
  input  logic signed [ValueW-1:0] ins_value_i,
  input  logic signed [ValueW-1:0] left_entry_i,
  input  logic                     left_less_i,
  input  logic signed [ValueW-1:0] right_entry_i,
  output logic signed [ValueW-1:0] entry_o,
  output logic                     less_o,
  output logic                     eq_o
);

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     less_q, eq_q;
  logic                     occupied;

  assign occupied = count_i > CNT_W'(IDX);

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      CELL_HOLD: entry_d = entry_q;
      CELL_INSERT: begin
        if (!less_q) begin
          entry_d = left_less_i ? ins_value_i : left_entry_i;
        end
      end
      CELL_REMOVE: begin
        if (!less_q) begin
          entry_d = right_entry_i;
        end
      end
      CELL_POP: entry_d = right_entry_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q <= 1'b0;
      eq_q   <= 1'b0;
    end else if (ctrl_i.sample) begin
      less_q <= occupied && (entry_q < cmp_value_i);
      eq_q   <= occupied && (entry_q == cmp_value_i);
    end
  end

  assign entry_o = entry_q;
  assign less_o  = less_q;
  assign eq_o    = eq_q;

endmodule

### src/sorted_list_engine.sv
// Channel  Dir  Fields                                   Handshake
// req_i    in   req_type[1:0], value[31:0] signed        valid/ready
// rsp_o    out  status[1:0], result_value[31:0] signed,  valid/ready
//               occupancy[4:0]
//
// Each request runs in order: the accept edge latches the compare flags of every
// cell, and the apply edge then shifts the cell chain and loads the result register.
// A new request is taken once the previous one has been applied; the result
// register lets the next request enter while a result still waits.
// A stalled result holds the apply state until the result register frees up.
// Reset empties the list at once; entry storage is not cleared.
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  sle_req_if.sink   req_i,
  sle_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e                   state_q, state_d;
  logic [CntW-1:0]          count_q, count_d;
  req_type_e                op_q;
  logic signed [ValueW-1:0] value_q;
  logic                     rsp_valid_q;
  logic [1:0]               rsp_status_q;
  logic signed [ValueW-1:0] rsp_value_q;
  logic [OccW-1:0]          rsp_occ_q;

  logic                     accept;
  logic                     apply;
  logic                     found;
  logic                     full;
  cell_ctrl_t               ctrl;
  status_e                  status_d;
  logic signed [ValueW-1:0] result_d;

  logic signed [ValueW-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]      less_w;
  logic [CAPACITY-1:0]      eq_w;

  assign accept = req_i.valid && req_i.ready;
  assign apply  = (state_q == ST_APPLY) && (!rsp_valid_q || rsp_o.ready);
  assign found  = |eq_w;
  assign full   = count_q == CntW'(CAPACITY);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_APPLY;
      ST_APPLY: if (apply) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = state_q == ST_IDLE;
    ctrl.sample = accept;
    ctrl.op     = CELL_HOLD;
    count_d     = count_q;
    status_d    = STAT_OK;
    result_d    = value_q;
    unique case (op_q)
      REQ_INSERT: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          ctrl.op = CELL_INSERT;
          count_d = count_q + CntW'(1);
        end
      end
      REQ_SEARCH: status_d = found ? STAT_OK : STAT_NOT_FOUND;
      REQ_DELETE: begin
        if (found) begin
          ctrl.op = CELL_REMOVE;
          count_d = count_q - CntW'(1);
        end else begin
          status_d = STAT_NOT_FOUND;
        end
      end
      REQ_POP: begin
        if (count_q == '0) begin
          status_d = STAT_EMPTY;
          result_d = '0;
        end else begin
          ctrl.op  = CELL_POP;
          result_d = entry_w[0];
          count_d  = count_q - CntW'(1);
        end
      end
      default: status_d = STAT_OK;
    endcase
    if (!apply) begin
      ctrl.op = CELL_HOLD;
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (apply) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= req_type_e'(req_i.req_type);
      value_q <= req_i.value;
    end
    if (apply) begin
      rsp_status_q <= status_d;
      rsp_value_q  <= result_d;
      rsp_occ_q    <= OccW'(count_d);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValueW-1:0] left_entry;
    logic                     left_less;
    logic signed [ValueW-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_entry = value_q;
      assign left_less  = 1'b1;
    end else begin : g_mid
      assign left_entry = entry_w[i-1];
      assign left_less  = less_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entry_w[i];
    end else begin : g_inner
      assign right_entry = entry_w[i+1];
    end

    sle_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .cmp_value_i   (req_i.value),
      .ins_value_i   (value_q),
      .left_entry_i  (left_entry),
      .left_less_i   (left_less),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[i]),
      .less_o        (less_w[i]),
      .eq_o          (eq_w[i])
    );
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.result_value = rsp_value_q;
  assign rsp_o.occupancy    = rsp_occ_q;

endmodule
